// ===== design/bhsf_pkg.sv =====
// Package for the bitplane horizontal span fill unit.
// Holds field widths, clamp limits and the controller/datapath interface types.
// Depends on nothing.
package bhsf_pkg;

    localparam int LINE_PIXELS = 320;
    localparam int ROWS        = 200;
    localparam int MAX_RESULTS = 20;

    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int COLOR_W  = 4;
    localparam int ADDR_W   = 24;
    localparam int STRIDE_W = 12;
    localparam int MASK_W   = 16;
    localparam int PROD_W   = ROW_W + STRIDE_W;
    localparam int GRP_W    = COL_W - 4;
    localparam int CFG_IDX_W = 1;

    localparam int COL_CAP   = MAX_RESULTS * 16 - 1;
    localparam int COL_LIMIT = (LINE_PIXELS - 1 < COL_CAP) ? LINE_PIXELS - 1 : COL_CAP;
    localparam int ROW_LIMIT = ROWS - 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 1'b1;

    localparam logic [ADDR_W-1:0]   FRAME_BASE_RST  = 24'h000000;
    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 12'd160;

    typedef struct packed {
        logic load;
        logic mul;
        logic base;
        logic step;
    } bhsf_cmd_t;

    typedef struct packed {
        logic last;
    } bhsf_status_t;

endpackage

// ===== design/bhsf_ctrl.sv =====
// Controller state machine of the span fill unit.
// Sequences load, multiply, base address and emit steps; uses bhsf_pkg.
module bhsf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bhsf_pkg::bhsf_status_t status,
    output bhsf_pkg::bhsf_cmd_t   cmd,
    output logic                  busy,
    output logic                  result_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_BASE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_EMIT);

endmodule

// ===== design/bhsf_datapath.sv =====
// Datapath of the span fill unit: configuration registers, span registers,
// row multiplier, address accumulator and edge masks; uses bhsf_pkg.
module bhsf_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bhsf_pkg::bhsf_cmd_t                   cmd,
    output bhsf_pkg::bhsf_status_t                status,
    input  logic                                  cfg_write,
    input  logic [bhsf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bhsf_pkg::ADDR_W-1:0]           cfg_data,
    input  logic [bhsf_pkg::COL_W-1:0]            x_start,
    input  logic [bhsf_pkg::COL_W-1:0]            x_end,
    input  logic [bhsf_pkg::ROW_W-1:0]            row,
    input  logic [bhsf_pkg::COLOR_W-1:0]          color,
    output logic [bhsf_pkg::ADDR_W-1:0]           word_address,
    output logic [bhsf_pkg::MASK_W-1:0]           pixel_mask,
    output logic [bhsf_pkg::COLOR_W-1:0]          plane_color,
    output logic                                  last_group
);

    logic [bhsf_pkg::ADDR_W-1:0]   frame_base_reg;
    logic [bhsf_pkg::STRIDE_W-1:0] line_stride_reg;

    logic [bhsf_pkg::COL_W-1:0]    left_reg;
    logic [bhsf_pkg::COL_W-1:0]    right_reg;
    logic [bhsf_pkg::ROW_W-1:0]    row_reg;
    logic [bhsf_pkg::COLOR_W-1:0]  color_reg;
    logic [bhsf_pkg::PROD_W-1:0]   prod_reg;
    logic [bhsf_pkg::ADDR_W-1:0]   addr_reg;
    logic [bhsf_pkg::GRP_W-1:0]    group_reg;

    logic [bhsf_pkg::COL_W-1:0]    xa_clamp;
    logic [bhsf_pkg::COL_W-1:0]    xb_clamp;
    logic [bhsf_pkg::ROW_W-1:0]    row_clamp;
    logic [bhsf_pkg::GRP_W-1:0]    group_first;
    logic [bhsf_pkg::GRP_W-1:0]    group_last;
    logic [bhsf_pkg::MASK_W-1:0]   left_mask;
    logic [bhsf_pkg::MASK_W-1:0]   right_mask;
    logic                          is_first;
    logic                          is_last;

    localparam logic [bhsf_pkg::COL_W-1:0] COL_MAX = bhsf_pkg::COL_W'(bhsf_pkg::COL_LIMIT);

    always_comb
    begin
        xa_clamp  = (x_start > COL_MAX) ? COL_MAX : x_start;
        xb_clamp  = (x_end > COL_MAX) ? COL_MAX : x_end;
        row_clamp = row;
        if (32'(row) > bhsf_pkg::ROW_LIMIT)
        begin
            row_clamp = bhsf_pkg::ROW_W'(bhsf_pkg::ROW_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= bhsf_pkg::FRAME_BASE_RST;
            line_stride_reg <= bhsf_pkg::LINE_STRIDE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bhsf_pkg::REG_FRAME_BASE:  frame_base_reg  <= cfg_data;
                bhsf_pkg::REG_LINE_STRIDE: line_stride_reg <= cfg_data[bhsf_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign group_first = left_reg[bhsf_pkg::COL_W-1:4];
    assign group_last  = right_reg[bhsf_pkg::COL_W-1:4];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (xa_clamp <= xb_clamp)
            begin
                left_reg  <= xa_clamp;
                right_reg <= xb_clamp;
            end
            else
            begin
                left_reg  <= xb_clamp;
                right_reg <= xa_clamp;
            end
            row_reg   <= row_clamp;
            color_reg <= color;
        end
        if (cmd.mul)
        begin
            prod_reg  <= bhsf_pkg::PROD_W'(row_reg) * bhsf_pkg::PROD_W'(line_stride_reg);
            group_reg <= group_first;
        end
        if (cmd.base)
        begin
            addr_reg <= frame_base_reg
                      + bhsf_pkg::ADDR_W'(prod_reg)
                      + bhsf_pkg::ADDR_W'({group_first, 3'b000});
        end
        if (cmd.step)
        begin
            addr_reg  <= addr_reg + bhsf_pkg::ADDR_W'(8);
            group_reg <= group_reg + bhsf_pkg::GRP_W'(1);
        end
    end

    assign is_first   = (group_reg == group_first);
    assign is_last    = (group_reg == group_last);
    assign left_mask  = 16'hFFFF >> left_reg[3:0];
    assign right_mask = 16'hFFFF << (4'd15 - right_reg[3:0]);

    assign status.last  = is_last;
    assign word_address = addr_reg;
    assign pixel_mask   = (is_first ? left_mask : 16'hFFFF) & (is_last ? right_mask : 16'hFFFF);
    assign plane_color  = color_reg;
    assign last_group   = cmd.step & is_last;

endmodule

// ===== design/bitplane_hline_span_fill_unit.sv =====
// Top level of the bitplane horizontal span fill unit.
// Joins bhsf_ctrl and bhsf_datapath; uses bhsf_pkg.
//
// A request is taken when start is high and busy is low. The unit then
// clamps and orders the endpoints, multiplies the row by the stride, adds
// the base address and then emits one masked write command per cycle from
// the address accumulator, one for each 16-pixel group the span covers
// (1 to 20). Each command is on the outputs for exactly one cycle with
// result_valid high, and the receiver cannot stall it. Write configuration
// registers only while busy is low.
module bitplane_hline_span_fill_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_write,
    input  logic [bhsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bhsf_pkg::ADDR_W-1:0]       cfg_data,
    input  logic [bhsf_pkg::COL_W-1:0]        x_start,
    input  logic [bhsf_pkg::COL_W-1:0]        x_end,
    input  logic [bhsf_pkg::ROW_W-1:0]        row,
    input  logic [bhsf_pkg::COLOR_W-1:0]      color,
    output logic                              result_valid,
    output logic [bhsf_pkg::ADDR_W-1:0]       word_address,
    output logic [bhsf_pkg::MASK_W-1:0]       pixel_mask,
    output logic [bhsf_pkg::COLOR_W-1:0]      plane_color,
    output logic                              last_group
);

    bhsf_pkg::bhsf_cmd_t    cmd;
    bhsf_pkg::bhsf_status_t status;

    bhsf_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    bhsf_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .x_start      (x_start),
        .x_end        (x_end),
        .row          (row),
        .color        (color),
        .word_address (word_address),
        .pixel_mask   (pixel_mask),
        .plane_color  (plane_color),
        .last_group   (last_group)
    );

endmodule

// ===== design/bhsf_checker.sv =====
// Port-level checker for the span fill unit and its bind to the top level.
// Depends on bitplane_hline_span_fill_unit.
module bhsf_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic last_group
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted request did not raise busy.");

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("Result strobe while not busy.");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_group |-> result_valid)
        else $error("Last group flag without a result strobe.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_group |=> !result_valid && !busy)
        else $error("Results continued after the last group.");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && last_group))
        else $error("Request ended without a last group command.");

endmodule

bind bitplane_hline_span_fill_unit bhsf_checker u_bhsf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .last_group   (last_group)
);
